>>> design/pblru_pkg.sv
`timescale 1ns / 1ps
package pblru_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int FILE_COUNT_DEF = 8;

  // command codes on the port
  localparam logic [2:0] CMD_OPEN     = 3'd0;
  localparam logic [2:0] CMD_CLOSE    = 3'd1;
  localparam logic [2:0] CMD_ALLOC    = 3'd2;
  localparam logic [2:0] CMD_LOAD     = 3'd3;
  localparam logic [2:0] CMD_TOUCH_RD = 3'd4;
  localparam logic [2:0] CMD_TOUCH_WR = 3'd5;

  // classified operations handed to the back end
  localparam logic [2:0] OP_NOP      = 3'd0;
  localparam logic [2:0] OP_OPEN     = 3'd1;
  localparam logic [2:0] OP_CLOSE    = 3'd2;
  localparam logic [2:0] OP_ALLOC    = 3'd3;
  localparam logic [2:0] OP_LOAD     = 3'd4;
  localparam logic [2:0] OP_TOUCH_RD = 3'd5;
  localparam logic [2:0] OP_TOUCH_WR = 3'd6;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NO_FILE     = 2'd1;
  localparam logic [1:0] ST_CLOSED_LOAD = 2'd2;
  localparam logic [1:0] ST_CLOSED_WB   = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  file;
    logic [31:0] page;
    logic [3:0]  slot;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        hit;
    logic [2:0]  opened_file;
    logic        write_back;
    logic [2:0]  victim_file;
    logic [31:0] victim_page;
    logic        read_in;
    logic        last;
  } result_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  function automatic result_t mk_res(logic [1:0] st, logic [3:0] slot, logic hit,
                                     logic [2:0] opened, logic wb, logic [2:0] vf,
                                     logic [31:0] vp, logic rd, logic last);
    result_t r;
    r.status      = st;
    r.slot_out    = slot;
    r.hit         = hit;
    r.opened_file = opened;
    r.write_back  = wb;
    r.victim_file = vf;
    r.victim_page = vp;
    r.read_in     = rd;
    r.last        = last;
    return r;
  endfunction

endpackage

>>> design/pblru_front.sv
`timescale 1ns / 1ps
module pblru_front import pblru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  command,
  input  logic [2:0]  file_id,
  input  logic [31:0] page_number,
  input  logic [3:0]  slot_id,
  output logic        busy,
  output queue_out_t  q_out,
  input  logic        q_take
);

  item_t      q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  item_t      cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.file = file_id;
    cls.page = page_number;
    cls.slot = slot_id;
    case (command)
      CMD_OPEN:     cls.op = OP_OPEN;
      CMD_CLOSE:    cls.op = OP_CLOSE;
      CMD_ALLOC:    cls.op = OP_ALLOC;
      CMD_LOAD:     cls.op = OP_LOAD;
      CMD_TOUCH_RD: cls.op = OP_TOUCH_RD;
      CMD_TOUCH_WR: cls.op = OP_TOUCH_WR;
      default:      cls.op = OP_NOP;
    endcase
  end

  assign busy        = (cnt == 2'd2);
  assign push        = start && !busy;
  assign pop         = q_take && (cnt != 2'd0);
  assign q_out.valid = (cnt != 2'd0);
  assign q_out.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

>>> design/pblru_back.sv
`timescale 1ns / 1ps
module pblru_back import pblru_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int FILE_COUNT = FILE_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  queue_out_t q_out,
  output logic       q_take,
  output logic       res_strobe,
  output result_t    res
);

  localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW   = (FILE_COUNT > 1) ? $clog2(FILE_COUNT) : 1;
  localparam int SCW  = $clog2(SLOT_COUNT + 1);
  localparam int FCW  = $clog2(FILE_COUNT + 1);
  localparam int FIW  = (FW > 3) ? FW : 3;
  localparam int SIW  = (SW > 4) ? SW : 4;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RUN   = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]      slot_file    [SLOT_COUNT];
  logic [31:0]     slot_page    [SLOT_COUNT];
  logic [SW-1:0]   slot_rank    [SLOT_COUNT];
  logic [SW-1:0]   free_stack   [SLOT_COUNT];
  logic [FW-1:0]   handle_stack [FILE_COUNT];
  logic [SLOT_COUNT-1:0] resident;
  logic [SLOT_COUNT-1:0] dirty;
  logic [FILE_COUNT-1:0] file_open;
  logic [SCW-1:0]  fcnt;
  logic [FCW-1:0]  hcnt;

  logic [2:0]      state;
  item_t           cur;
  logic [SW-1:0]   idx;
  logic            hit_reg;
  logic [SW-1:0]   hit_idx;
  logic [SW-1:0]   vic_idx;
  logic [SW-1:0]   top_slot;
  logic [FW-1:0]   top_file;

  logic [SCW-1:0]  fcnt_m1;
  logic [FCW-1:0]  hcnt_m1;
  logic            match_any;
  logic [SW-1:0]   match_idx;
  logic [SW-1:0]   lru_idx;
  logic [SIW-1:0]  sx;
  logic            touch_ok;
  logic [SW-1:0]   ts;

  function automatic logic is_open(logic [2:0] f, logic [FILE_COUNT-1:0] om);
    logic [FIW-1:0] fx;
    fx = FIW'(f);
    return (fx < FILE_COUNT) && om[fx[FW-1:0]];
  endfunction

  assign fcnt_m1  = fcnt - 1'b1;
  assign hcnt_m1  = hcnt - 1'b1;
  assign sx       = SIW'(cur.slot);
  assign touch_ok = (sx < SLOT_COUNT) && resident[sx[SW-1:0]];
  assign ts       = sx[SW-1:0];
  assign q_take   = (state == S_IDLE) && q_out.valid;

  // tag compare and LRU pick: the LRU slot holds the top rank when the pool is full
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    lru_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (resident[i] && slot_file[i] == cur.file && slot_page[i] == cur.page) begin
        match_any = 1'b1;
        match_idx = SW'(i);
      end
      if (resident[i] && slot_rank[i] == SW'(SLOT_COUNT - 1)) begin
        lru_idx = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_strobe <= 1'b0;
      resident   <= '0;
      dirty      <= '0;
      file_open  <= '0;
      fcnt       <= SCW'(SLOT_COUNT);
      hcnt       <= FCW'(FILE_COUNT);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        free_stack[i] <= SW'(SLOT_COUNT - 1 - i);
      end
      for (int i = 0; i < FILE_COUNT; i++) begin
        handle_stack[i] <= FW'(FILE_COUNT - 1 - i);
      end
    end else begin
      res_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_out.valid) begin
            cur   <= q_out.item;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          hit_reg  <= match_any;
          hit_idx  <= match_idx;
          vic_idx  <= lru_idx;
          top_slot <= free_stack[fcnt_m1[SW-1:0]];
          top_file <= handle_stack[hcnt_m1[FW-1:0]];
          idx      <= '0;
          case (cur.op)
            OP_OPEN, OP_ALLOC, OP_LOAD: state <= S_PLACE;
            OP_CLOSE: begin
              if (is_open(cur.file, file_open)) begin
                state <= S_CLOSE;
              end else begin
                res_strobe <= 1'b1;
                res   <= mk_res(ST_OK, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                state <= S_IDLE;
              end
            end
            OP_TOUCH_RD, OP_TOUCH_WR: begin
              res_strobe <= 1'b1;
              res   <= mk_res(ST_OK, cur.slot, touch_ok, '0, 1'b0, '0, '0, 1'b0, 1'b1);
              if (touch_ok) begin
                if (cur.op == OP_TOUCH_WR) begin
                  dirty[ts] <= 1'b1;
                end
                for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (resident[i] && slot_rank[i] < slot_rank[ts]) begin
                    slot_rank[i] <= slot_rank[i] + 1'b1;
                  end
                end
                slot_rank[ts] <= '0;
              end
              state <= S_IDLE;
            end
            default: begin
              res_strobe <= 1'b1;
              res   <= mk_res(ST_OK, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
              state <= S_IDLE;
            end
          endcase
        end
        S_PLACE: begin
          res_strobe <= 1'b1;
          state      <= S_IDLE;
          if (cur.op == OP_OPEN) begin
            if (hcnt == '0) begin
              res <= mk_res(ST_NO_FILE, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
              file_open[top_file] <= 1'b1;
              hcnt <= hcnt_m1;
              res  <= mk_res(ST_OK, '0, 1'b0, 3'(top_file), 1'b0, '0, '0, 1'b0, 1'b1);
            end
          end else if (hit_reg) begin
            res <= mk_res(ST_OK, 4'(hit_idx), 1'b1, '0, 1'b0, '0, '0, 1'b0, 1'b1);
          end else if (cur.op == OP_LOAD && !is_open(cur.file, file_open)) begin
            res <= mk_res(ST_CLOSED_LOAD, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
          end else if (fcnt == '0) begin
            if (dirty[vic_idx] && !is_open(slot_file[vic_idx], file_open)) begin
              res <= mk_res(ST_CLOSED_WB, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
              // evict and refill the same slot in place: the free stack is not touched
              res <= mk_res(ST_OK, 4'(vic_idx), 1'b0, '0, dirty[vic_idx],
                            dirty[vic_idx] ? slot_file[vic_idx] : 3'd0,
                            dirty[vic_idx] ? slot_page[vic_idx] : 32'd0,
                            cur.op == OP_LOAD, 1'b1);
              for (int i = 0; i < SLOT_COUNT; i++) begin
                if (resident[i] && SW'(i) != vic_idx) begin
                  slot_rank[i] <= slot_rank[i] + 1'b1;
                end
              end
              slot_rank[vic_idx] <= '0;
              dirty[vic_idx]     <= 1'b0;
              slot_file[vic_idx] <= cur.file;
              slot_page[vic_idx] <= cur.page;
            end
          end else begin
            res <= mk_res(ST_OK, 4'(top_slot), 1'b0, '0, 1'b0, '0, '0,
                          cur.op == OP_LOAD, 1'b1);
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (resident[i]) begin
                slot_rank[i] <= slot_rank[i] + 1'b1;
              end
            end
            resident[top_slot]  <= 1'b1;
            dirty[top_slot]     <= 1'b0;
            slot_rank[top_slot] <= '0;
            slot_file[top_slot] <= cur.file;
            slot_page[top_slot] <= cur.page;
            fcnt <= fcnt_m1;
          end
        end
        S_CLOSE: begin
          // walk slots in ascending order, one per cycle
          if (resident[idx] && slot_file[idx] == cur.file) begin
            if (dirty[idx]) begin
              res_strobe <= 1'b1;
              res <= mk_res(ST_OK, 4'(idx), 1'b0, '0, 1'b1, cur.file, slot_page[idx],
                            1'b0, 1'b0);
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
              if (resident[i] && SW'(i) != idx && slot_rank[i] > slot_rank[idx]) begin
                slot_rank[i] <= slot_rank[i] - 1'b1;
              end
            end
            resident[idx] <= 1'b0;
            dirty[idx]    <= 1'b0;
            if (fcnt < SLOT_COUNT) begin
              free_stack[fcnt[SW-1:0]] <= idx;
              fcnt <= fcnt + 1'b1;
            end
          end
          if (idx == SW'(SLOT_COUNT - 1)) begin
            state <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FIN: begin
          file_open[FW'(cur.file)] <= 1'b0;
          if (hcnt < FILE_COUNT) begin
            handle_stack[hcnt[FW-1:0]] <= FW'(cur.file);
            hcnt <= hcnt + 1'b1;
          end
          res_strobe <= 1'b1;
          res   <= mk_res(ST_OK, '0, 1'b0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/page_buffer_lru_tag_controller.sv
`timescale 1ns / 1ps
// Tag and LRU controller of a page buffer pool. Issue a command by raising
// start while busy is low; a two-entry command queue lets up to two commands
// wait while one executes. Results come out one per cycle on result_strobe
// and cannot be stalled, in command order; the final result of a command has
// last set. Touch, unused codes and a close of a file that is not open give
// their result straight from the tag compare and stack read step; open,
// allocate and load go on to place or evict, and a close of an open file
// walks every slot once and then gives its final result.
module page_buffer_lru_tag_controller import pblru_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int FILE_COUNT = FILE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [2:0]  file_id,
  input  logic [31:0] page_number,
  input  logic [3:0]  slot_id,
  output logic        result_strobe,
  output logic [1:0]  status,
  output logic [3:0]  slot_out,
  output logic        hit,
  output logic [2:0]  opened_file,
  output logic        write_back,
  output logic [2:0]  victim_file,
  output logic [31:0] victim_page,
  output logic        read_in,
  output logic        last
);

  queue_out_t q_out;
  logic       q_take;
  result_t    res;

  pblru_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .command     (command),
    .file_id     (file_id),
    .page_number (page_number),
    .slot_id     (slot_id),
    .busy        (busy),
    .q_out       (q_out),
    .q_take      (q_take)
  );

  pblru_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .FILE_COUNT (FILE_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_out      (q_out),
    .q_take     (q_take),
    .res_strobe (result_strobe),
    .res        (res)
  );

  assign status      = res.status;
  assign slot_out    = res.slot_out;
  assign hit         = res.hit;
  assign opened_file = res.opened_file;
  assign write_back  = res.write_back;
  assign victim_file = res.victim_file;
  assign victim_page = res.victim_page;
  assign read_in     = res.read_in;
  assign last        = res.last;

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && status != ST_OK |-> last)
    else $error("error result without last");

  a_wb_ok: assert property (@(posedge clk) disable iff (rst)
    result_strobe && write_back |-> status == ST_OK && !hit)
    else $error("write-back on error or hit");

  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    result_strobe && hit |-> !read_in && last)
    else $error("hit asks for fill");

endmodule

>>> test/page_buffer_lru_tag_controller_tb.sv
`timescale 1ns / 1ps
module page_buffer_lru_tag_controller_tb;
  import pblru_pkg::*;

  localparam int NSLOT = 16;
  localparam int NFILE = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  class pool_scoreboard;
    logic [2:0]  slot_file [NSLOT];
    logic [31:0] slot_page [NSLOT];
    bit          resident [NSLOT];
    bit          dirty [NSLOT];
    int          rank [NSLOT];
    int          free_slots [$];
    bit          is_open [NFILE];
    int          free_files [$];
    result_t     pending [$];
    int          mismatches;
    int          checked;
    int          write_backs;
    int          hits;
    int          errors_seen;

    function new();
      mismatches = 0;
      checked = 0;
      write_backs = 0;
      hits = 0;
      errors_seen = 0;
      for (int i = 0; i < NSLOT; i++) begin
        resident[i] = 0;
        dirty[i] = 0;
        rank[i] = 0;
        slot_file[i] = '0;
        slot_page[i] = '0;
        free_slots.push_front(i);
      end
      for (int i = 0; i < NFILE; i++) begin
        is_open[i] = 0;
        free_files.push_front(i);
      end
    endfunction

    function void push(logic [1:0] st, logic [3:0] slot, logic h, logic [2:0] of,
                       logic wb, logic [2:0] vf, logic [31:0] vp, logic rd,
                       logic lst);
      result_t r;
      r.status = st;
      r.slot_out = slot;
      r.hit = h;
      r.opened_file = of;
      r.write_back = wb;
      r.victim_file = vf;
      r.victim_page = vp;
      r.read_in = rd;
      r.last = lst;
      pending.push_back(r);
    endfunction

    function void release_slot(int s);
      for (int i = 0; i < NSLOT; i++)
        if (resident[i] && i != s && rank[i] > rank[s]) rank[i]--;
      resident[s] = 0;
      dirty[s] = 0;
      free_slots.push_back(s);
    endfunction

    function void place_page(logic [2:0] f, logic [31:0] p, logic fill);
      int victim;
      int s;
      logic wb;
      logic [2:0] vf;
      logic [31:0] vp;
      wb = 0;
      vf = '0;
      vp = '0;
      if (free_slots.size() == 0) begin
        victim = -1;
        for (int i = 0; i < NSLOT; i++)
          if (resident[i] && (victim < 0 || rank[i] > rank[victim])) victim = i;
        if (victim < 0) begin
          push(ST_CLOSED_WB, 0, 0, 0, 0, 0, 0, 0, 1);
          return;
        end
        if (dirty[victim]) begin
          if (!is_open[slot_file[victim]]) begin
            errors_seen++;
            push(ST_CLOSED_WB, 0, 0, 0, 0, 0, 0, 0, 1);
            return;
          end
          wb = 1;
          vf = slot_file[victim];
          vp = slot_page[victim];
        end
        release_slot(victim);
      end
      s = free_slots.pop_back();
      for (int i = 0; i < NSLOT; i++)
        if (resident[i]) rank[i]++;
      resident[s] = 1;
      dirty[s] = 0;
      rank[s] = 0;
      slot_file[s] = f;
      slot_page[s] = p;
      push(ST_OK, s[3:0], 0, 0, wb, vf, vp, fill, 1);
    endfunction

    // Work out the results of one accepted command.
    function void note_command(logic [2:0] cmd, logic [2:0] f, logic [31:0] p,
                               logic [3:0] sl);
      int h;
      int fh;
      case (cmd)
        CMD_OPEN: begin
          if (free_files.size() == 0) begin
            errors_seen++;
            push(ST_NO_FILE, 0, 0, 0, 0, 0, 0, 0, 1);
          end else begin
            fh = free_files.pop_back();
            is_open[fh] = 1;
            push(ST_OK, 0, 0, fh[2:0], 0, 0, 0, 0, 1);
          end
        end
        CMD_CLOSE: begin
          if (is_open[f]) begin
            for (int i = 0; i < NSLOT; i++)
              if (resident[i] && slot_file[i] == f) begin
                if (dirty[i]) push(ST_OK, i[3:0], 0, 0, 1, f, slot_page[i], 0, 0);
                release_slot(i);
              end
            is_open[f] = 0;
            free_files.push_back(int'(f));
          end
          push(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1);
        end
        CMD_ALLOC, CMD_LOAD: begin
          h = -1;
          for (int i = 0; i < NSLOT; i++)
            if (h < 0 && resident[i] && slot_file[i] == f && slot_page[i] == p) h = i;
          if (h >= 0) push(ST_OK, h[3:0], 1, 0, 0, 0, 0, 0, 1);
          else if (cmd == CMD_LOAD && !is_open[f]) begin
            errors_seen++;
            push(ST_CLOSED_LOAD, 0, 0, 0, 0, 0, 0, 0, 1);
          end else place_page(f, p, cmd == CMD_LOAD);
        end
        CMD_TOUCH_RD, CMD_TOUCH_WR: begin
          if (resident[sl]) begin
            if (cmd == CMD_TOUCH_WR) dirty[sl] = 1;
            for (int i = 0; i < NSLOT; i++)
              if (resident[i] && i != sl && rank[i] < rank[sl]) rank[i]++;
            rank[sl] = 0;
            push(ST_OK, sl, 1, 0, 0, 0, 0, 0, 1);
          end else push(ST_OK, sl, 0, 0, 0, 0, 0, 0, 1);
        end
        default: push(ST_OK, 0, 0, 0, 0, 0, 0, 0, 1);
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.write_back) write_backs++;
      if (got.hit) hits++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] command = '0;
  logic [2:0] file_id = '0;
  logic [31:0] page_number = '0;
  logic [3:0] slot_id = '0;
  logic busy, result_strobe, hit, write_back, read_in, last;
  logic [1:0] status;
  logic [3:0] slot_out;
  logic [2:0] opened_file, victim_file;
  logic [31:0] victim_page;

  pool_scoreboard board;
  int idle_cycles = 0;
  bit gaps_on;
  int issued;

  always #5 clk = ~clk;

  page_buffer_lru_tag_controller dut (.*);

  // Sample both handshakes at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        board.note_command(command, file_id, page_number, slot_id);
      end
      if (result_strobe) begin
        board.check_result({status, slot_out, hit, opened_file, write_back,
                            victim_file, victim_page, read_in, last});
      end
      if ((start && !busy) || result_strobe) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d results outstanding", board.pending.size());
        $display("page_buffer_lru_tag_controller_tb failed");
        $finish;
      end
    end
  end

  task automatic send(logic [2:0] cmd, logic [2:0] f, logic [31:0] p, logic [3:0] s);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    start <= 1;
    command <= cmd;
    file_id <= f;
    page_number <= p;
    slot_id <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    issued++;
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (board.pending.size() != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  // Pick mostly open files and a small page set so hits and evictions happen.
  task automatic random_command();
    int r;
    logic [2:0] f;
    logic [31:0] p;
    r = $urandom_range(0, 99);
    f = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) != 0)
      for (int i = 0; i < 8; i++) if (!board.is_open[f]) f = 3'($urandom_range(0, 7));
    p = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 23));
    if (r < 8) send(CMD_OPEN, 3'($urandom), 32'($urandom), 4'($urandom));
    else if (r < 14) send(CMD_CLOSE, f, 32'($urandom), 4'($urandom));
    else if (r < 34) send(CMD_ALLOC, f, p, 4'($urandom));
    else if (r < 56) send(CMD_LOAD, f, p, 4'($urandom));
    else if (r < 74) send(CMD_TOUCH_RD, 3'($urandom), 32'($urandom), 4'($urandom));
    else if (r < 96) send(CMD_TOUCH_WR, 3'($urandom), 32'($urandom), 4'($urandom));
    else send(3'($urandom_range(6, 7)), 3'($urandom), 32'($urandom), 4'($urandom));
  endtask

  initial begin
    board = new();
    issued = 0;
    gaps_on = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: touch empty, load closed, opens to exhaustion, extremes.
    send(CMD_TOUCH_RD, 3'd7, 32'hFFFF_FFFF, 4'd15);
    send(CMD_LOAD, 3'd0, 32'd0, 4'd0);
    send(CMD_CLOSE, 3'd5, 32'd0, 4'd0);
    send(3'd6, 3'd7, 32'hFFFF_FFFF, 4'd15);
    send(3'd7, 3'd0, 32'd0, 4'd0);
    for (int i = 0; i < 9; i++) send(CMD_OPEN, 3'd0, 32'd0, 4'd0);
    send(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF, 4'd0);
    send(CMD_LOAD, 3'd7, 32'hFFFF_FFFF, 4'd0);
    send(CMD_LOAD, 3'd0, 32'hAAAA_5555, 4'd0);
    send(CMD_TOUCH_WR, 3'd0, 32'd0, 4'd15);
    send(CMD_TOUCH_WR, 3'd0, 32'd0, 4'd0);
    send(CMD_TOUCH_RD, 3'd0, 32'd0, 4'd1);
    send(CMD_CLOSE, 3'd7, 32'd0, 4'd0);
    drain();

    // Fill the pool, dirty pages of a file, close it, then do the same with a second file.
    for (int i = 0; i < 18; i++) send(CMD_LOAD, 3'd1, 32'h5555_0000 + i, 4'd0);
    for (int i = 0; i < 16; i++) send(CMD_TOUCH_WR, 3'd0, 32'd0, i[3:0]);
    send(CMD_ALLOC, 3'd2, 32'd99, 4'd0);
    send(CMD_CLOSE, 3'd1, 32'd0, 4'd0);
    for (int i = 0; i < 16; i++) send(CMD_ALLOC, 3'd6, i, 4'd0);
    for (int i = 0; i < 16; i++) send(CMD_TOUCH_WR, 3'd0, 32'd0, i[3:0]);
    send(CMD_CLOSE, 3'd6, 32'd0, 4'd0);
    send(CMD_ALLOC, 3'd6, 32'd100, 4'd0);
    send(CMD_LOAD, 3'd3, 32'd100, 4'd0);
    drain();

    gaps_on = 1;
    for (int i = 0; i < 300; i++) random_command();
    drain();
    gaps_on = 0;
    for (int i = 0; i < 100; i++) random_command();
    drain();

    $display("sent %0d commands, checked %0d results: %0d hits, %0d write-backs",
             issued, board.checked, board.hits, board.write_backs);
    $display("error statuses expected: %0d", board.errors_seen);
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("page_buffer_lru_tag_controller_tb passed");
    else
      $display("page_buffer_lru_tag_controller_tb failed");
    $finish;
  end
endmodule
